FILE: rtl/counter_to_alphabet_string_unit_assert.svh
// assertion macros shared by the rtl
`ifndef COUNTER_TO_ALPHABET_STRING_UNIT_ASSERT_SVH
`define COUNTER_TO_ALPHABET_STRING_UNIT_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define CTAS_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define CTAS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ctas_pkg.sv
package ctas_pkg;

    // fixed field widths
    localparam int COUNTER_W = 64;
    localparam int SLOT_W    = 6;
    localparam int CHAR_W    = 8;
    localparam int POS_W     = 4;
    localparam int RADIX_W   = 7;
    localparam int STRLEN_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    // divider steps, one quotient bit each
    localparam int DIV_STEPS = COUNTER_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_ENCODE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHARSET_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRING_LENGTH  = 2'd1;

    typedef struct packed {
        logic                 opcode;
        logic [COUNTER_W-1:0] counter;
        logic [SLOT_W-1:0]    table_index;
        logic [CHAR_W-1:0]    table_char;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic [POS_W-1:0]  position;
        logic              last;
    } out_item_t;

    // divider result, valid while done is high
    typedef struct packed {
        logic                 done;
        logic [COUNTER_W-1:0] quotient;
        logic [RADIX_W-1:0]   remainder;
    } div_result_t;

endpackage

FILE: rtl/ctas_divider.sv
module ctas_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ctas_pkg::COUNTER_W-1:0] dividend,
    input  logic [ctas_pkg::RADIX_W-1:0]   divisor,
    output ctas_pkg::div_result_t          result
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [ctas_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [ctas_pkg::COUNTER_W-1:0] dq_reg, dq_next;
    logic [ctas_pkg::RADIX_W-1:0]   rem_reg, rem_next;
    logic [ctas_pkg::RADIX_W-1:0]   div_reg, div_next;
    logic [ctas_pkg::RADIX_W:0]     trial;
    logic                           fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {rem_reg, dq_reg[ctas_pkg::COUNTER_W-1]};
        fits  = (trial >= {1'b0, div_reg});
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            dq_next   = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            dq_next  = {dq_reg[ctas_pkg::COUNTER_W-2:0], fits};
            rem_next = fits ? ctas_pkg::RADIX_W'(trial - {1'b0, div_reg})
                            : trial[ctas_pkg::RADIX_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == ctas_pkg::STEP_W'(ctas_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign result.done      = done_reg;
    assign result.quotient  = dq_reg;
    assign result.remainder = rem_reg;

endmodule

FILE: rtl/ctas_alphabet.sv
module ctas_alphabet #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [ctas_pkg::CHAR_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [ctas_pkg::CHAR_W-1:0] rd_data
);

    logic [ctas_pkg::CHAR_W-1:0] mem [DEPTH];
    logic [ctas_pkg::CHAR_W-1:0] rd_data_reg;

    // single write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/counter_to_alphabet_string_unit.sv
// encode item: each character needs a division by the 64-step shift-subtract divider
// and a table lookup; the next division starts once that character is taken
// load item: writes the alphabet, no result, next item may follow directly
// one item in work at a time; s_ready is low until the last character is taken
// synchronous active-low reset clears control, sets charset_length 64, string_length 8;
// alphabet contents stay undefined until loaded
module counter_to_alphabet_string_unit #(
    parameter int ALPHABET_SIZE = 64,
    parameter int MAX_LENGTH    = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ctas_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ctas_pkg::out_item_t              m_data,
    input  logic                             cfg_we,
    input  logic [ctas_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ctas_pkg::CFG_DATA_W-1:0]  cfg_data
);

    `include "counter_to_alphabet_string_unit_assert.svh"

    localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int KW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t                           state_reg, state_next;
    logic [KW-1:0]                    k_reg, k_next;
    logic [ctas_pkg::RADIX_W-1:0]     charset_reg;
    logic [ctas_pkg::STRLEN_W-1:0]    strlen_reg;
    logic [ctas_pkg::RADIX_W-1:0]     radix;
    logic [KW-1:0]                    last_idx;
    logic                             is_last;
    logic                             s_fire;
    logic                             m_fire;
    logic                             div_start;
    logic [ctas_pkg::COUNTER_W-1:0]   div_dividend;
    ctas_pkg::div_result_t            div_res;
    logic                             wr_en;
    logic [ctas_pkg::CHAR_W-1:0]      rd_data;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            charset_reg <= ctas_pkg::RADIX_W'(64);
            strlen_reg  <= ctas_pkg::STRLEN_W'(8);
        end else if (cfg_we) begin
            unique case (cfg_index)
                ctas_pkg::REG_CHARSET_LENGTH: charset_reg <= cfg_data;
                ctas_pkg::REG_STRING_LENGTH:  strlen_reg  <= cfg_data[ctas_pkg::STRLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp radix and length into range
    always_comb begin
        if (charset_reg == '0) begin
            radix = ctas_pkg::RADIX_W'(1);
        end else if (int'(charset_reg) > ALPHABET_SIZE) begin
            radix = ctas_pkg::RADIX_W'(ALPHABET_SIZE);
        end else begin
            radix = charset_reg;
        end
        if (strlen_reg == '0) begin
            last_idx = '0;
        end else if (int'(strlen_reg) > MAX_LENGTH) begin
            last_idx = KW'(MAX_LENGTH - 1);
        end else begin
            last_idx = KW'(int'(strlen_reg) - 1);
        end
    end

    assign is_last = (k_reg == last_idx);
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;

    // load items write the alphabet straight away
    assign wr_en = s_fire && (s_data.opcode == ctas_pkg::OP_LOAD)
                   && (int'(s_data.table_index) < ALPHABET_SIZE);

    // sequencer: divide, look up, hand out, repeat per digit
    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        div_start    = 1'b0;
        div_dividend = div_res.quotient;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_data.opcode == ctas_pkg::OP_ENCODE)) begin
                    div_start    = 1'b1;
                    div_dividend = s_data.counter;
                    k_next       = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_fire) begin
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        div_start  = 1'b1;
                        k_next     = k_reg + 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    ctas_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (radix),
        .result   (div_res)
    );

    // digit lookup fires as the remainder comes out
    ctas_alphabet #(
        .DEPTH (ALPHABET_SIZE),
        .AW    (AW)
    ) u_alphabet (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(s_data.table_index)),
        .wr_data (s_data.table_char),
        .rd_en   (div_res.done),
        .rd_addr (AW'(div_res.remainder)),
        .rd_data (rd_data)
    );

    assign m_data.character = rd_data;
    assign m_data.position  = ctas_pkg::POS_W'(k_reg);
    assign m_data.last      = is_last;

    `CTAS_ASSERT_SAME(a_ready_excl_valid, s_ready, !m_valid, "input ready while a character is shown")
    `CTAS_ASSERT_NEXT(a_last_frees_input, m_fire && m_data.last, s_ready, "not ready after last item")
    `CTAS_ASSERT_SAME(a_done_in_div, div_res.done, state_reg == ST_DIV, "divider done outside divide")
    `CTAS_ASSERT_SAME(a_pos_in_range, m_valid, k_reg <= last_idx, "position beyond string length")
    `CTAS_ASSERT_SAME(a_digit_below_radix, div_res.done, div_res.remainder < radix, "digit not below radix")

endmodule
